// ===== hw/rtl/sdq_pkg.sv =====
package sdq_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [31:0] UPS_RESET = 32'd1000000;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        STS_QUEUED   = 3'd0,
        STS_REJ_NEG  = 3'd1,
        STS_REJ_FULL = 3'd2,
        STS_WOKEN    = 3'd3,
        STS_NONE     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_IN_RD,
        S_IN_CMP,
        S_TK_RD,
        S_TK_CMP,
        S_EMIT
    } t_state;

    localparam logic OP_DELAY = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // circular index stepping
    function automatic t_idx sdq_next(input t_idx p);
        t_idx r;
        if (p == t_idx'(MAX_ENTRIES - 1)) begin
            r = '0;
        end else begin
            r = p + t_idx'(1);
        end
        return r;
    endfunction

    function automatic t_idx sdq_prev(input t_idx p);
        t_idx r;
        if (p == '0) begin
            r = t_idx'(MAX_ENTRIES - 1);
        end else begin
            r = p - t_idx'(1);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sdq_channels.sv =====
interface sdq_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [7:0]         tag;
    logic signed [31:0] secs;
    logic [31:0]        now;

    modport source(output valid, op, tag, secs, now, input ready);
    modport sink(input valid, op, tag, secs, now, output ready);
endinterface

interface sdq_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] woken_tag;
    logic       last;

    modport source(output valid, status, woken_tag, last, input ready);
    modport sink(input valid, status, woken_tag, last, output ready);
endinterface

interface sdq_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/sorted_delay_queue.sv =====
// Sorted delay queue. Holds up to MAX_ENTRIES (tag, wake time) entries in
// wake-time order in a small circular buffer. A delay beat (op = 0) computes
// wake = now + secs * units_per_second (mod 2^32) and inserts it behind all
// entries with an equal or earlier wake time; it returns one result beat:
// queued, rejected negative (checked first) or rejected full. A tick beat
// (op = 1) pops from the head every entry whose wake time is <= now (plain
// unsigned compare), one woken beat per entry with last on the final one, or
// one "none" beat if nothing expired. The block takes one beat at a time:
// i_req.ready is high only while idle. A single 32-bit compare unit walks the
// one-port entry memory one entry at a time: an accepted delay passes the
// later-waking entries and stops behind an earlier one or at the head; a
// tick pops expired entries and stops on an unexpired one or when the queue
// is empty; a rejected delay does no walk. Output stalls hold the block busy.
// The result beat sits in an output register. units_per_second resets to
// 1000000 and is written through i_cfg, which is always ready; write it only
// while the block is idle.
module sorted_delay_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdq_in_if.sink    i_req,
    sdq_out_if.source o_res,
    sdq_cfg_if.sink   i_cfg
);
    import sdq_pkg::*;

    // control state
    t_state r_state, n_state;
    t_idx   r_head, n_head;      // physical slot of logical entry 0
    t_idx   r_tail, n_tail;      // first free slot
    t_cnt   r_cnt, n_cnt;        // stored entries
    logic   r_pend, n_pend;      // an expired entry waits to be reported
    logic   r_ov;                // output register full
    logic [31:0] r_ups;          // units_per_second

    // work registers
    logic [31:0] r_key, n_key;   // now on ticks, wake time on delays
    logic [31:0] r_acc, n_acc;   // secs * units_per_second
    logic [31:0] r_secs;
    logic [7:0]  r_tag;
    logic [7:0]  r_ptag, n_ptag; // tag of the pending expired entry
    t_idx        r_wp, n_wp;     // insertion write slot while walking
    t_cnt        r_left, n_left; // entries still ahead of the walk
    t_status     r_sts, n_sts;   // final beat status
    logic [7:0]  r_etag, n_etag; // final beat tag

    // output register
    t_status     r_osts;
    logic [7:0]  r_otag;
    logic        r_olast;

    // entry memory, registered read
    logic [31:0] r_mem_wake [MAX_ENTRIES];
    logic [7:0]  r_mem_tag  [MAX_ENTRIES];
    logic [31:0] r_rd_wake;
    logic [7:0]  r_rd_tag;

    logic        rd_en, wr_en;
    t_idx        rd_addr, wr_addr;
    logic [31:0] wr_wake;
    logic [7:0]  wr_tag;

    // beat into the output register
    logic    emit, can_emit;
    t_status e_sts;
    logic [7:0] e_tag;
    logic    e_last;

    logic        accept;
    logic [31:0] prod;       // low word of secs * units_per_second
    logic        cmp_le;     // the shared compare unit

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid     = r_ov;
    assign o_res.status    = r_osts;
    assign o_res.woken_tag = r_otag;
    assign o_res.last      = r_olast;

    assign can_emit = !r_ov || o_res.ready;
    assign prod     = r_secs * r_ups;
    assign cmp_le   = (r_rd_wake <= r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            r_ups   <= UPS_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_ups <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_acc  <= n_acc;
        r_ptag <= n_ptag;
        r_wp   <= n_wp;
        r_left <= n_left;
        r_sts  <= n_sts;
        r_etag <= n_etag;
        if (accept) begin
            r_secs <= i_req.secs;
            r_tag  <= i_req.tag;
        end
        if (emit) begin
            r_osts  <= e_sts;
            r_otag  <= e_tag;
            r_olast <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_wake[wr_addr] <= wr_wake;
            r_mem_tag[wr_addr]  <= wr_tag;
        end
        if (rd_en) begin
            r_rd_wake <= r_mem_wake[rd_addr];
            r_rd_tag  <= r_mem_tag[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_key   = r_key;
        n_acc   = r_acc;
        n_ptag  = r_ptag;
        n_wp    = r_wp;
        n_left  = r_left;
        n_sts   = r_sts;
        n_etag  = r_etag;
        rd_en   = 1'b0;
        rd_addr = r_head;
        wr_en   = 1'b0;
        wr_addr = r_wp;
        wr_wake = r_key;
        wr_tag  = r_tag;
        emit    = 1'b0;
        e_sts   = r_sts;
        e_tag   = r_etag;
        e_last  = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key  = i_req.now;
                    n_etag = '0;
                    n_pend = 1'b0;
                    if (i_req.op == OP_TICK) begin
                        n_state = S_TK_RD;
                    end else if (i_req.secs[31]) begin
                        n_sts   = STS_REJ_NEG;
                        n_state = S_EMIT;
                    end else if (r_cnt == t_cnt'(MAX_ENTRIES)) begin
                        n_sts   = STS_REJ_FULL;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end

            S_MUL: begin
                n_acc   = prod;
                n_state = S_ADD;
            end

            S_ADD: begin
                n_key   = r_key + r_acc;
                n_wp    = r_tail;
                n_left  = r_cnt;
                n_state = S_IN_RD;
            end

            // walk from the tail toward the head, moving later entries up
            S_IN_RD: begin
                if (r_left == '0) begin
                    wr_en   = 1'b1;
                    n_tail  = sdq_next(r_tail);
                    n_cnt   = r_cnt + t_cnt'(1);
                    n_sts   = STS_QUEUED;
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = sdq_prev(r_wp);
                    n_state = S_IN_CMP;
                end
            end

            S_IN_CMP: begin
                wr_en = 1'b1;
                if (cmp_le) begin
                    n_tail  = sdq_next(r_tail);
                    n_cnt   = r_cnt + t_cnt'(1);
                    n_sts   = STS_QUEUED;
                    n_state = S_EMIT;
                end else begin
                    wr_wake = r_rd_wake;
                    wr_tag  = r_rd_tag;
                    n_wp    = sdq_prev(r_wp);
                    n_left  = r_left - t_cnt'(1);
                    n_state = S_IN_RD;
                end
            end

            // pop from the head; one expired entry is held back so the
            // last flag is known when it leaves
            S_TK_RD: begin
                if (r_cnt == '0) begin
                    n_sts   = r_pend ? STS_WOKEN : STS_NONE;
                    n_etag  = r_pend ? r_ptag : 8'd0;
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = S_TK_CMP;
                end
            end

            S_TK_CMP: begin
                if (!cmp_le) begin
                    n_sts   = r_pend ? STS_WOKEN : STS_NONE;
                    n_etag  = r_pend ? r_ptag : 8'd0;
                    n_state = S_EMIT;
                end else if (!r_pend || can_emit) begin
                    emit    = r_pend;
                    e_sts   = STS_WOKEN;
                    e_tag   = r_ptag;
                    e_last  = 1'b0;
                    n_pend  = 1'b1;
                    n_ptag  = r_rd_tag;
                    n_head  = sdq_next(r_head);
                    n_cnt   = r_cnt - t_cnt'(1);
                    n_state = S_TK_RD;
                end
            end

            S_EMIT: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sdq_checker.sv =====
module sdq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_status,
    input logic [7:0] i_out_tag,
    input logic       i_out_last
);
    import sdq_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // one beat at a time: no second accept right after one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    // everything but a woken beat is a lone final beat with a zero tag
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != STS_WOKEN) |-> i_out_last && (i_out_tag == 8'd0))
        else $error("non-woken beat not final or tag set");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_delay_queue sdq_checker u_sdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_status(o_res.status),
    .i_out_tag   (o_res.woken_tag),
    .i_out_last  (o_res.last)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import sdq_pkg::*;

    // pops per tick are capped at this many beats
    localparam int POP_LIMIT      = 8;
    // idle cycles with nothing expected before a register write
    localparam int SETTLE_CYCLES  = 25;
    // cycles without any beat on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;
    // the one long output hold-off, and when it starts
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 100;
    // last request beats are sent and drained with no idling
    localparam int TAIL_ITEMS     = 40;
    localparam int END_QUIET      = 40;

    typedef enum logic [1:0] {
        PLAN_ITEM,
        PLAN_CFG,
        PLAN_SYNC
    } t_plan_kind;

    typedef struct packed {
        t_plan_kind  kind;
        logic        op;
        logic [7:0]  tag;
        logic [31:0] secs;
        logic [31:0] now;
        logic [31:0] ups;
    } t_plan;

    typedef struct packed {
        t_status    status;
        logic [7:0] woken_tag;
        logic       last;
    } t_wakeup;

    logic i_clk;
    logic i_rst_n;

    sdq_in_if  req_if ();
    sdq_out_if res_if ();
    sdq_cfg_if cfg_if ();

    sorted_delay_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // stimulus plan and expected result beats
    t_plan   pending_beats[$];
    t_wakeup due_results[$];

    // shadow of the delay queue
    logic [31:0] model_wake [MAX_ENTRIES];
    logic [7:0]  model_owner[MAX_ENTRIES];
    int          model_count;
    logic [31:0] model_ups;

    // driver state
    t_plan       live_req;
    logic [31:0] live_ups;
    int          gap_left;
    int          settle;
    bit          tail_mode;

    // monitor state
    int stall_left;
    int hold_left;
    bit pressure_done;

    int quiet;
    int items_total;
    int items_sent;
    int cfg_writes;
    int res_beats;
    int fault_count;
    int status_seen[8];

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic void await_result(input t_status s, input logic [7:0] t,
                                         input logic l);
        t_wakeup w;
        w.status    = s;
        w.woken_tag = t;
        w.last      = l;
        due_results.push_back(w);
    endfunction

    // Applies one accepted request beat to the shadow queue and lines up
    // the result beats it should produce.
    function automatic void predict_wakeups(input t_plan beat);
        logic [31:0] wake;
        int          pos;
        int          popped;
        int          i;
        if (beat.op == OP_DELAY) begin
            if (beat.secs[31]) begin
                // negative delay wins over a full store
                await_result(STS_REJ_NEG, 8'd0, 1'b1);
            end else if (model_count >= MAX_ENTRIES) begin
                await_result(STS_REJ_FULL, 8'd0, 1'b1);
            end else begin
                // low 32 bits of the product, then wrap on the add
                wake = beat.now + beat.secs * model_ups;
                pos = 0;
                while (pos < model_count && model_wake[pos] <= wake) begin
                    pos++;
                end
                for (i = model_count; i > pos; i--) begin
                    model_wake[i]  = model_wake[i-1];
                    model_owner[i] = model_owner[i-1];
                end
                model_wake[pos]  = wake;
                model_owner[pos] = beat.tag;
                model_count++;
                await_result(STS_QUEUED, 8'd0, 1'b1);
            end
        end else begin
            popped = 0;
            while (popped < model_count && popped < POP_LIMIT &&
                   model_wake[popped] <= beat.now) begin
                popped++;
            end
            if (popped == 0) begin
                await_result(STS_NONE, 8'd0, 1'b1);
            end else begin
                for (i = 0; i < popped; i++) begin
                    await_result(STS_WOKEN, model_owner[i], (i + 1 == popped));
                end
                for (i = popped; i < model_count; i++) begin
                    model_wake[i-popped]  = model_wake[i];
                    model_owner[i-popped] = model_owner[i];
                end
                model_count -= popped;
            end
        end
    endfunction

    //------------------------------------------------------------------
    // Plan building
    //------------------------------------------------------------------
    function automatic void add_item(input logic op, input logic [7:0] tag,
                                     input logic [31:0] secs, input logic [31:0] now);
        t_plan p;
        p.kind = PLAN_ITEM;
        p.op   = op;
        p.tag  = tag;
        p.secs = secs;
        p.now  = now;
        p.ups  = '0;
        pending_beats.push_back(p);
        items_total++;
    endfunction

    // waits for the block to drain, then rewrites units_per_second
    function automatic void add_rate(input logic [31:0] ups);
        t_plan p;
        p      = '0;
        p.kind = PLAN_SYNC;
        pending_beats.push_back(p);
        p.kind = PLAN_CFG;
        p.ups  = ups;
        pending_beats.push_back(p);
    endfunction

    // Mostly well-formed traffic: delays of a few seconds taken at the
    // running clock, ticks that move the clock forward so that entries
    // expire, plus about one beat in eight of pure noise.
    function automatic void plan_random_phase(input logic [31:0] ups,
                                              input logic [31:0] t_start, input int count);
        logic [31:0] t;
        int          n;
        int          pick;
        add_rate(ups);
        // flush whatever the previous phase left behind
        add_item(OP_TICK, 8'($urandom), $urandom, 32'hFFFF_FFFF);
        t = t_start;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                add_item(OP_DELAY, 8'($urandom_range(0, 255)), $urandom_range(0, 8), t);
            end else if (pick < 88) begin
                if (ups <= 32'd1000000) begin
                    t = t + ups * $urandom_range(0, 3) + $urandom_range(0, 2);
                end else begin
                    t = t + $urandom_range(0, 64);
                end
                add_item(OP_TICK, 8'($urandom), $urandom, t);
            end else begin
                add_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom, $urandom);
            end
        end
    endfunction

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    //------------------------------------------------------------------
    // Request and config driver
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            cfg_if.valid <= 1'b0;
            gap_left = 0;
            settle   = 0;
        end else begin
            // retire beats taken at this edge
            if (req_if.valid && req_if.ready) begin
                predict_wakeups(live_req);
                items_sent++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                model_ups = live_ups;
                cfg_writes++;
            end
            tail_mode = (items_total - items_sent) <= TAIL_ITEMS;

            if ((req_if.valid && !req_if.ready) || (cfg_if.valid && !cfg_if.ready)) begin
                // beat still on offer, hold it
            end else if (pending_beats.size() == 0) begin
                req_if.valid <= 1'b0;
                cfg_if.valid <= 1'b0;
            end else begin
                case (pending_beats[0].kind)
                    PLAN_SYNC: begin
                        // register writes only once the block is idle
                        req_if.valid <= 1'b0;
                        cfg_if.valid <= 1'b0;
                        if (due_results.size() == 0) begin
                            settle++;
                        end else begin
                            settle = 0;
                        end
                        if (settle >= SETTLE_CYCLES) begin
                            settle = 0;
                            void'(pending_beats.pop_front());
                        end
                    end
                    PLAN_CFG: begin
                        req_if.valid <= 1'b0;
                        live_ups = pending_beats[0].ups;
                        cfg_if.data  <= live_ups;
                        cfg_if.valid <= 1'b1;
                        void'(pending_beats.pop_front());
                    end
                    default: begin
                        cfg_if.valid <= 1'b0;
                        if (gap_left > 0) begin
                            gap_left--;
                            req_if.valid <= 1'b0;
                        end else if (!tail_mode && $urandom_range(0, 5) == 0) begin
                            // idle burst: this cycle and then gap_left more
                            gap_left = $urandom_range(0, 8);
                            req_if.valid <= 1'b0;
                        end else begin
                            live_req = pending_beats.pop_front();
                            req_if.op    <= live_req.op;
                            req_if.tag   <= live_req.tag;
                            req_if.secs  <= live_req.secs;
                            req_if.now   <= live_req.now;
                            req_if.valid <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    //------------------------------------------------------------------
    // Result monitor and output backpressure
    //------------------------------------------------------------------
    task automatic check_result();
        t_wakeup want;
        if (due_results.size() == 0) begin
            $error("unexpected result beat: status %0d woken_tag %0d last %0d",
                   res_if.status, res_if.woken_tag, res_if.last);
            fault_count++;
        end else begin
            want = due_results.pop_front();
            if (res_if.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, res_if.status);
                fault_count++;
            end
            if (res_if.woken_tag !== want.woken_tag) begin
                $error("woken_tag: expected %0d, got %0d", want.woken_tag,
                       res_if.woken_tag);
                fault_count++;
            end
            if (res_if.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, res_if.last);
                fault_count++;
            end
        end
        res_beats++;
        if (!$isunknown(res_if.status)) begin
            status_seen[res_if.status]++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_result();
            end
            // one long hold-off so the block backs up into its input
            if (!pressure_done && res_beats >= HOLD_AT_RESULT) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (tail_mode) begin
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Watchdog: any beat on any channel counts as progress
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet = 0;
        end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
                     (cfg_if.valid && cfg_if.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet, due_results.size());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Plan, reset and end of run
    //------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.op    = OP_DELAY;
        req_if.tag   = '0;
        req_if.secs  = '0;
        req_if.now   = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        model_count  = 0;
        model_ups    = UPS_RESET;

        // directed, rate left at its reset value
        add_item(OP_TICK,  8'h00, 32'd0, 32'd0);                     // empty: none expired
        add_item(OP_DELAY, 8'h00, 32'hFFFF_FFFF, 32'd0);             // -1 rejected
        add_item(OP_DELAY, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF);     // most negative
        // fill the store; equal wake times must keep arrival order
        add_item(OP_DELAY, 8'd10, 32'd2, 32'd100);
        add_item(OP_DELAY, 8'd11, 32'd1, 32'd100);
        add_item(OP_DELAY, 8'd12, 32'd2, 32'd100);
        add_item(OP_DELAY, 8'd13, 32'd0, 32'hFFFF_FFFF);
        add_item(OP_DELAY, 8'd14, 32'd1, 32'd100);
        add_item(OP_DELAY, 8'd15, 32'h7FFF_FFFF, 32'd5);
        add_item(OP_DELAY, 8'd16, 32'd0, 32'd0);
        add_item(OP_DELAY, 8'd17, 32'd3, 32'd100);
        add_item(OP_DELAY, 8'hFF, 32'd5, 32'd100);                   // store full
        add_item(OP_DELAY, 8'hA5, 32'hFFFF_FFFB, 32'd100);           // negative while full
        // ticks carry junk in tag and secs
        add_item(OP_TICK,  8'hAA, 32'hFFFF_FFFF, 32'd50);
        add_item(OP_TICK,  8'h55, 32'h7FFF_FFFF, 32'hFFFF_FFFF);     // pop everything
        add_item(OP_TICK,  8'h00, 32'd0, 32'd0);

        // zero rate: wake time equals now
        add_rate(32'd0);
        add_item(OP_DELAY, 8'h3C, 32'h7FFF_FFFF, 32'd1000);
        add_item(OP_TICK,  8'h00, 32'd0, 32'd999);
        add_item(OP_TICK,  8'h00, 32'd0, 32'd1000);

        // largest rate: wake times wrap and expire at once
        add_rate(32'hFFFF_FFFF);
        add_item(OP_DELAY, 8'h81, 32'd1, 32'd1);
        add_item(OP_TICK,  8'h7E, 32'h8000_0000, 32'd0);
        add_item(OP_DELAY, 8'h42, 32'd3, 32'hFFFF_FFF0);
        add_item(OP_TICK,  8'h00, 32'd0, 32'hFFFF_FFED);

        // random phases, one rate each, the extremes among them
        plan_random_phase(32'd1, 32'd100, 70);
        plan_random_phase(UPS_RESET, 32'd5000, 70);
        plan_random_phase(32'd7, 32'd0, 66);
        plan_random_phase(32'hFFFF_FFFF, 32'h8000_0000, 60);
        plan_random_phase($urandom, $urandom, 60);
        plan_random_phase(32'd2, 32'hFFFF_FF00, 70);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_sent < items_total || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_QUIET) @(posedge i_clk);

        $display("run: %0d request beats, %0d result beats, %0d rate writes",
                 items_sent, res_beats, cfg_writes);
        $display("run: queued %0d, negative %0d, full %0d, woken %0d, none expired %0d",
                 status_seen[STS_QUEUED], status_seen[STS_REJ_NEG],
                 status_seen[STS_REJ_FULL], status_seen[STS_WOKEN], status_seen[STS_NONE]);
        if (fault_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== sorted_delay_queue.f =====
hw/rtl/sdq_pkg.sv
hw/rtl/sdq_channels.sv
hw/rtl/sorted_delay_queue.sv
hw/rtl/sdq_checker.sv
sim/testbench.sv
